// ----- hdl/ust_pkg.sv -----
`timescale 1ns / 1ps

package ust_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    // Stored value width: the input field is 32 bits wide, so at most 32 bits survive.
    localparam int ENTRY_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ERASE_RD,
        S_ERASE_WR,
        S_INS_WR,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // start a new item: latch value, rewind scan
        logic step;        // issue the next scan read
        logic erase_rd;    // read the tail entry and shrink the count
        logic wr_slot;     // write the tail entry into the hit slot
        logic wr_tail;     // append the value and grow the count
        logic out_load;    // load the result register
        logic out_success;
        logic out_full;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;         // the entry read last cycle matches the value
        logic scan_done;   // every live entry has been compared
        logic full;        // the table holds CAPACITY entries
        logic out_free;    // the result register can take a new result
    } t_dp_status;

endpackage

// ----- hdl/ust_datapath.sv -----
`timescale 1ns / 1ps

module ust_datapath
    import ust_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_value,
    input  t_ctl_cmd            i_cmd,
    output t_dp_status          o_status,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_success,
    output logic                o_full_res,
    output logic [COUNT_W-1:0]  o_count
);

    logic [ENTRY_W-1:0] r_mem [CAPACITY];

    logic [ENTRY_W-1:0] r_value;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_slot;
    logic               r_rd_vld;
    logic               r_out_vld;
    logic               r_out_success;
    logic               r_out_full;
    logic [COUNT_W-1:0] r_out_count;

    logic                     issue;
    logic                     hit;
    logic [CNT_W-1:0]         tail;
    logic [IDX_W-1:0]         rd_addr;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign issue     = i_cmd.step && (r_idx < r_count);
    assign hit       = r_rd_vld && (r_rd_data == r_value);
    assign tail      = r_count - CNT_W'(1);
    assign rd_addr   = i_cmd.erase_rd ? tail[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.wr_tail) begin
            r_mem[r_count[IDX_W-1:0]] <= r_value;
        end else if (i_cmd.wr_slot) begin
            r_mem[r_slot] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_value <= i_value[ENTRY_W-1:0];
        end
        if (issue) begin
            r_rd_idx <= r_idx[IDX_W-1:0];
        end
        if (hit) begin
            r_slot <= r_rd_idx;
        end
        if (i_cmd.out_load) begin
            r_out_success <= i_cmd.out_success;
            r_out_full    <= i_cmd.out_full;
            r_out_count   <= count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.clear) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.wr_tail) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.erase_rd) begin
                r_count <= tail;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.hit       = hit;
    assign o_status.scan_done = !r_rd_vld && (r_idx >= r_count);
    assign o_status.full      = (r_count >= CNT_W'(CAPACITY));
    assign o_status.out_free  = !r_out_vld || i_ready;

    assign o_valid    = r_out_vld;
    assign o_success  = r_out_success;
    assign o_full_res = r_out_full;
    assign o_count    = r_out_count;

endmodule

// ----- hdl/ust_controller.sv -----
`timescale 1ns / 1ps

module ust_controller
    import ust_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_status       i_status,
    output t_ctl_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;
    t_cmd   n_cmd;
    logic   r_succ;
    logic   n_succ;
    logic   r_full;
    logic   n_full;
    logic   take;

    assign take = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_NOP;
            r_succ  <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_succ  <= n_succ;
            r_full  <= n_full;
        end
    end

    // Next state and the outcome flags of the item.
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_succ  = r_succ;
        n_full  = r_full;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_cmd  = t_cmd'(i_command);
                    n_succ = 1'b0;
                    n_full = 1'b0;
                    n_state = (t_cmd'(i_command) == CMD_NOP) ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    unique case (r_cmd)
                        CMD_ERASE: begin
                            n_succ  = 1'b1;
                            n_state = S_ERASE_RD;
                        end
                        CMD_QUERY: begin
                            n_succ  = 1'b1;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (i_status.scan_done) begin
                    if (r_cmd == CMD_INSERT) begin
                        if (i_status.full) begin
                            n_full  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_succ  = 1'b1;
                            n_state = S_INS_WR;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ERASE_RD: n_state = S_ERASE_WR;
            S_ERASE_WR: n_state = S_DONE;
            S_INS_WR:   n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_cmd.out_success = r_succ;
        o_cmd.out_full    = r_full;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.clear = take;
            end
            S_SEARCH:   o_cmd.step     = !i_status.hit;
            S_ERASE_RD: o_cmd.erase_rd = 1'b1;
            S_ERASE_WR: o_cmd.wr_slot  = 1'b1;
            S_INS_WR:   o_cmd.wr_tail  = 1'b1;
            S_DONE:     o_cmd.out_load = i_status.out_free;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/unordered_set_table.sv -----
`timescale 1ns / 1ps
// Unordered set table: up to CAPACITY distinct values kept in a RAM with a
// live-entry count. Each input transfer carries a command (insert, erase,
// membership query) and a value; each one produces exactly one output
// transfer with a success flag, a full flag and the count after the command.
// Both channels use valid/ready. The block takes one command at a time:
// o_ready is high only while no command is in progress. Each command runs a
// linear scan that reads one RAM entry per cycle through the single
// registered read port and compares it in the following cycle. Erase then
// moves the tail entry into the freed slot (S_ERASE_RD, then S_ERASE_WR);
// insert then appends the value in S_INS_WR. The next command can be
// accepted in the cycle after the result is loaded. Results sit in an
// output register, so the next command is accepted while the previous
// result still waits for i_ready; if the receiver stalls, the following
// command finishes its work and then waits for the register.
// Synchronous active-low reset empties the set (count zero) and clears the
// handshakes; RAM contents are not cleared, since only entries below the
// count are ever read. Command code 3 is a no-op that reports the count.

module unordered_set_table
    import ust_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [31:0]        i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_success,
    output logic               o_full_res,
    output logic [COUNT_W-1:0] o_count
);

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // Sequencer: scan, tail move, append and result hand-off.
    ust_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (ctl_cmd)
    );

    // Table RAM, scan counter, live count and output register.
    ust_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (ctl_cmd),
        .o_status   (dp_status),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_success  (o_success),
        .o_full_res (o_full_res),
        .o_count    (o_count)
    );

endmodule

// ----- hdl/ust_checker.sv -----
`timescale 1ns / 1ps

module ust_checker
    import ust_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_success,
    input logic               o_full_res,
    input logic [COUNT_W-1:0] o_count
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_success) && $stable(o_full_res)
            && $stable(o_count))
        else $error("result changed while stalled");

    // A refused insert only happens at a full table.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_res |-> o_count == COUNT_W'(CAPACITY))
        else $error("full flag with room left");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_success && o_full_res))
        else $error("success and full together");

    // Every command leaves the idle state after its transfer, so acceptance is
    // never back to back.
    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("two commands accepted in a row");

endmodule

bind unordered_set_table ust_checker u_ust_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_success  (o_success),
    .o_full_res (o_full_res),
    .o_count    (o_count)
);
